// ===== hw/rtl/csr_ewt_pkg.sv =====
package csr_ewt_pkg;

	// graph sizes
	localparam int NODE_COUNT  = 1024;
	localparam int ARC_COUNT   = 4096;
	localparam int WEIGHT_BITS = 32;

	// derived widths
	localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int OIDX_W = $clog2(NODE_COUNT + 1);
	localparam int ARC_W  = (ARC_COUNT > 1) ? $clog2(ARC_COUNT) : 1;
	localparam int OFF_W  = $clog2(ARC_COUNT + 1);

	// opcodes
	localparam logic [2:0] OP_WR_OFFSET = 3'd0;
	localparam logic [2:0] OP_WR_TARGET = 3'd1;
	localparam logic [2:0] OP_WR_WEIGHT = 3'd2;
	localparam logic [2:0] OP_LOOKUP    = 3'd3;
	localparam logic [2:0] OP_UPDATE    = 3'd4;

	// weight selectors
	localparam logic [1:0] SEL_PLAIN = 2'd0;
	localparam logic [1:0] SEL_UP    = 2'd1;
	localparam logic [1:0] SEL_DOWN  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// request beat
	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] slot;
		logic [9:0]  from_node;
		logic [9:0]  to_node;
		logic [1:0]  weight_select;
		logic [31:0] data_value;
	} item_t;

	// response beat
	typedef struct packed {
		logic [31:0] weight_out;
		logic [1:0]  status;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic setup;
		logic scan;
		logic load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic search;
		logic hit;
		logic miss;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/csr_ewt_ctrl.sv =====
module csr_ewt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	output csr_ewt_pkg::ctl_cmd_t ctl,
	input  csr_ewt_pkg::ctl_sts_t sts
);
	import csr_ewt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_RANGE = 5'b00100,
		S_SCAN  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = sts.search ? S_RANGE : S_DONE;
			end
			S_RANGE: begin
				ctl.setup = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.hit || sts.miss) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one request in flight at a time
	assign cmd_stall = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/csr_ewt_dp.sv =====
module csr_ewt_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csr_ewt_pkg::ctl_cmd_t ctl,
	output csr_ewt_pkg::ctl_sts_t sts,
	input  csr_ewt_pkg::item_t    cmd_data,
	input  logic                  cfg_valid,
	input  logic [31:0]           cfg_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output csr_ewt_pkg::result_t  rsp_data
);
	import csr_ewt_pkg::*;

	item_t                  item_q;
	logic [31:0]            no_path_q;

	// storage
	logic [OFF_W-1:0]       off_mem   [NODE_COUNT+1];
	logic [NODE_W-1:0]      tgt_mem   [ARC_COUNT];
	logic [WEIGHT_BITS-1:0] plain_mem [ARC_COUNT];
	logic [WEIGHT_BITS-1:0] up_mem    [ARC_COUNT];
	logic [WEIGHT_BITS-1:0] down_mem  [ARC_COUNT];

	logic [OFF_W-1:0]       off_lo_rd_q;
	logic [OFF_W-1:0]       off_hi_rd_q;
	logic [NODE_W-1:0]      tgt_rd_q;
	logic [WEIGHT_BITS-1:0] plain_rd_q;
	logic [WEIGHT_BITS-1:0] up_rd_q;
	logic [WEIGHT_BITS-1:0] down_rd_q;

	// scan state
	logic [OFF_W-1:0]       cur_q;
	logic [OFF_W-1:0]       end_q;
	logic                   pend_s1;
	logic [ARC_W-1:0]       idx_s1;
	logic                   scan_q;

	// pending result
	logic [31:0]            res_w_q;
	logic [1:0]             res_st_q;
	logic                   take_mem_q;
	logic                   rsp_valid_q;
	result_t                rsp_q;

	logic [31:0]            slot_w;
	logic [31:0]            src_w;
	logic [31:0]            src_nx_w;
	logic [31:0]            dst_w;
	logic [31:0]            val;
	logic                   slot_off_ok;
	logic                   slot_arc_ok;
	logic                   tgt_ok;
	logic                   src_ok;
	logic                   sel_ok;
	logic                   sel_updn;
	logic                   is_update;
	logic                   wr_off;
	logic                   wr_tgt;
	logic                   wr_wt;
	logic                   search;
	logic                   simple_ok;
	logic                   issue;
	logic                   hit;
	logic                   miss;
	logic [OFF_W-1:0]       off_val;
	logic                   off_we;
	logic                   tgt_we;
	logic                   wt_we;
	logic [ARC_W-1:0]       wt_addr;
	logic [WEIGHT_BITS-1:0] wt_data;
	logic [WEIGHT_BITS-1:0] sel_rd;
	logic                   out_free;

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= cmd_data;
		end
	end

	// no-path register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_path_q <= 32'hFFFF_FFFF;
		end else if (cfg_valid) begin
			no_path_q <= cfg_data;
		end
	end

	// field range checks
	assign slot_w      = 32'(item_q.slot);
	assign src_w       = 32'(item_q.from_node);
	assign src_nx_w    = src_w + 32'd1;
	assign dst_w       = 32'(item_q.to_node);
	assign val         = item_q.data_value;
	assign slot_off_ok = (slot_w <= 32'(NODE_COUNT));
	assign slot_arc_ok = (slot_w < 32'(ARC_COUNT));
	assign tgt_ok      = (val < 32'(NODE_COUNT));
	assign src_ok      = (src_w < 32'(NODE_COUNT));
	assign sel_updn    = (item_q.weight_select == SEL_UP) || (item_q.weight_select == SEL_DOWN);
	assign sel_ok      = sel_updn || (item_q.weight_select == SEL_PLAIN);
	assign is_update   = (item_q.opcode == OP_UPDATE);

	// opcode decode
	always_comb begin
		wr_off = 1'b0;
		wr_tgt = 1'b0;
		wr_wt  = 1'b0;
		search = 1'b0;
		unique case (item_q.opcode)
			OP_WR_OFFSET: wr_off = slot_off_ok;
			OP_WR_TARGET: wr_tgt = slot_arc_ok && tgt_ok;
			OP_WR_WEIGHT: wr_wt  = slot_arc_ok && sel_ok;
			OP_LOOKUP:    search = sel_ok;
			OP_UPDATE:    search = sel_updn;
			default:      search = 1'b0;
		endcase
	end

	assign simple_ok = wr_off || wr_tgt || wr_wt;

	// scan window, open from range setup until hit or miss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
		end else if (ctl.setup) begin
			scan_q <= 1'b1;
		end else if (hit || miss) begin
			scan_q <= 1'b0;
		end
	end

	// arc scan compare
	assign issue = (cur_q < end_q);
	assign hit   = scan_q && pend_s1 && (32'(tgt_rd_q) == dst_w);
	assign miss  = scan_q && !pend_s1 && !issue;

	// offset store, read at both ends of the source range
	assign off_val = (val > 32'(ARC_COUNT)) ? OFF_W'(ARC_COUNT) : val[OFF_W-1:0];
	assign off_we  = ctl.exec && wr_off;

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[slot_w[OIDX_W-1:0]] <= off_val;
		end
		off_lo_rd_q <= off_mem[src_w[OIDX_W-1:0]];
		off_hi_rd_q <= off_mem[src_nx_w[OIDX_W-1:0]];
	end

	// target store, one arc read per scan cycle
	assign tgt_we = ctl.exec && wr_tgt;

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[slot_w[ARC_W-1:0]] <= val[NODE_W-1:0];
		end
		if (ctl.scan && issue) begin
			tgt_rd_q <= tgt_mem[cur_q[ARC_W-1:0]];
		end
	end

	// weight write port: load by slot or update at the matched arc
	assign wt_we   = (ctl.exec && wr_wt) || (hit && is_update);
	assign wt_addr = ctl.exec ? slot_w[ARC_W-1:0] : idx_s1;
	assign wt_data = WEIGHT_BITS'(val);

	always_ff @(posedge clk) begin
		if (wt_we && (item_q.weight_select == SEL_PLAIN)) begin
			plain_mem[wt_addr] <= wt_data;
		end
		if (hit) begin
			plain_rd_q <= plain_mem[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (wt_we && (item_q.weight_select == SEL_UP)) begin
			up_mem[wt_addr] <= wt_data;
		end
		if (hit) begin
			up_rd_q <= up_mem[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (wt_we && (item_q.weight_select == SEL_DOWN)) begin
			down_mem[wt_addr] <= wt_data;
		end
		if (hit) begin
			down_rd_q <= down_mem[idx_s1];
		end
	end

	// scan pointer and range end
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			cur_q <= off_lo_rd_q;
			end_q <= src_ok ? off_hi_rd_q : off_lo_rd_q;
		end else if (ctl.scan && issue) begin
			cur_q <= cur_q + OFF_W'(1);
		end
		if (ctl.scan && issue) begin
			idx_s1 <= cur_q[ARC_W-1:0];
		end
	end

	// target read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (ctl.setup) begin
			pend_s1 <= 1'b0;
		end else if (ctl.scan) begin
			pend_s1 <= issue;
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (ctl.exec && !search) begin
			res_w_q    <= '0;
			res_st_q   <= simple_ok ? ST_DONE : ST_BAD;
			take_mem_q <= 1'b0;
		end else if (hit) begin
			res_w_q    <= '0;
			res_st_q   <= ST_DONE;
			take_mem_q <= !is_update;
		end else if (miss) begin
			res_w_q    <= no_path_q;
			res_st_q   <= ST_NONE;
			take_mem_q <= 1'b0;
		end
	end

	// selected weight
	always_comb begin
		case (item_q.weight_select)
			SEL_UP:   sel_rd = up_rd_q;
			SEL_DOWN: sel_rd = down_rd_q;
			default:  sel_rd = plain_rd_q;
		endcase
	end

	// response register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rsp_q.weight_out <= take_mem_q ? 32'(sel_rd) : res_w_q;
			rsp_q.status     <= res_st_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;
	assign sts.search   = search;
	assign sts.hit      = hit;
	assign sts.miss     = miss;
	assign sts.out_free = out_free;

endmodule

// ===== hw/rtl/csr_edge_weight_table.sv =====
// channel   direction  handshake        beat
// cmd       in         valid / stall    cmd_data (item_t)
// rsp       out        valid / stall    rsp_data (result_t)
// cfg       in         valid / ready    cfg_data, no-path weight
//
// writes and rejected requests: accept, execute, then response load.
// lookup and update: accept, execute, range setup, then the arc scan until the
// first matching arc or the end of the node's arc range, then response load;
// one target memory read per cycle sets the scan length.
// reset clears control and sets the no-path weight to all ones; graph storage
// holds nothing meaningful until loaded.
// a stalled response waits in the output register; the next request is taken
// meanwhile and holds in its last cycle until the register frees up.
module csr_edge_weight_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  csr_ewt_pkg::item_t   cmd_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output csr_ewt_pkg::result_t rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);
	import csr_ewt_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	// register writes always accepted
	assign cfg_ready = 1'b1;

	// sequencer
	csr_ewt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	// storage, scan and response
	csr_ewt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_data  (cmd_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== hw/rtl/csr_ewt_checker.sv =====
module csr_ewt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_stall,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input csr_ewt_pkg::result_t rsp_data
);
	import csr_ewt_pkg::*;

	// an accepted request keeps the input stalled through the execute step and the step after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall ##1 cmd_stall)
		else $error("request accepted while previous one still in work");

	// a new response only comes out of a busy cycle
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response appeared without request in work");

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// rejected requests carry zero weight
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_BAD) |-> (rsp_data.weight_out == '0))
		else $error("bad request returned a weight");

	// status is always a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == ST_DONE) || (rsp_data.status == ST_NONE)
			|| (rsp_data.status == ST_BAD))
		else $error("undefined response status");

endmodule

bind csr_edge_weight_table csr_ewt_checker u_csr_ewt_checker (.*);

// ===== tb/csr_edge_weight_table_test.sv =====
`timescale 1ns / 100ps

module csr_edge_weight_table_test;

	import csr_ewt_pkg::*;

	// selector code that names no weight store
	localparam logic [1:0] SEL_NONE = 2'd3;

	// opcodes the block does not define
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	localparam logic [31:0] WEIGHT_MASK =
		(WEIGHT_BITS >= 32) ? '1 : ((32'h1 << WEIGHT_BITS) - 32'h1);

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	item_t       cmd_data;
	logic        rsp_valid;
	logic        rsp_stall;
	result_t     rsp_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// shadow copy of the graph and the no-path register
	logic [31:0]     no_path_w;
	logic [OFF_W-1:0]  off_mem   [NODE_COUNT+1];
	bit                off_known [NODE_COUNT+1];
	logic [NODE_W-1:0] tgt_mem   [ARC_COUNT];
	bit                tgt_known [ARC_COUNT];
	logic [31:0]       wt_mem    [3][ARC_COUNT];
	bit                wt_known  [3][ARC_COUNT];
	int                built_nodes[$];

	// results still owed by the block, oldest first
	result_t pending_rsp[$];

	int idle_max        = 12;
	int rsp_wait_left   = 0;
	int rsp_hold_cycles = 0;
	int err_count       = 0;

	csr_edge_weight_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#12_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// first arc of src whose target is dst, or -1
	function automatic int first_arc(input logic [9:0] src, input logic [9:0] dst);
		int lo;
		int hi;
		if (src >= NODE_COUNT)
			return -1;
		lo = int'(off_mem[src]);
		hi = int'(off_mem[src + 1]);
		if (hi > ARC_COUNT)
			hi = ARC_COUNT;
		for (int a = lo; a < hi; a++)
			if (tgt_mem[a] == dst)
				return a;
		return -1;
	endfunction

	// true when a request touches only loaded graph entries
	function automatic bit reads_defined(input item_t it);
		int lo;
		int hi;
		if (it.opcode == OP_LOOKUP) begin
			if (it.weight_select == SEL_NONE)
				return 1'b1;
		end else if (it.opcode == OP_UPDATE) begin
			if (it.weight_select != SEL_UP && it.weight_select != SEL_DOWN)
				return 1'b1;
		end else begin
			return 1'b1;
		end
		if (it.from_node >= NODE_COUNT)
			return 1'b1;
		if (!off_known[it.from_node] || !off_known[it.from_node + 1])
			return 1'b0;
		lo = int'(off_mem[it.from_node]);
		hi = int'(off_mem[it.from_node + 1]);
		if (hi > ARC_COUNT)
			hi = ARC_COUNT;
		for (int a = lo; a < hi; a++) begin
			if (!tgt_known[a])
				return 1'b0;
			if (tgt_mem[a] == it.to_node)
				return (it.opcode == OP_UPDATE) || wt_known[it.weight_select][a];
		end
		return 1'b1;
	endfunction

	// apply one request to the shadow graph and queue its result
	task automatic table_apply(input item_t it);
		result_t r;
		int      arc;
		r.weight_out = '0;
		r.status     = ST_BAD;
		case (it.opcode)
			OP_WR_OFFSET: begin
				if (it.slot <= NODE_COUNT) begin
					off_mem[it.slot]   = (it.data_value > ARC_COUNT) ?
						OFF_W'(ARC_COUNT) : it.data_value[OFF_W-1:0];
					off_known[it.slot] = 1'b1;
					r.status = ST_DONE;
				end
			end
			OP_WR_TARGET: begin
				if (it.slot < ARC_COUNT && it.data_value < NODE_COUNT) begin
					tgt_mem[it.slot]   = it.data_value[NODE_W-1:0];
					tgt_known[it.slot] = 1'b1;
					r.status = ST_DONE;
				end
			end
			OP_WR_WEIGHT: begin
				if (it.slot < ARC_COUNT && it.weight_select != SEL_NONE) begin
					wt_mem[it.weight_select][it.slot]   = it.data_value & WEIGHT_MASK;
					wt_known[it.weight_select][it.slot] = 1'b1;
					r.status = ST_DONE;
				end
			end
			OP_LOOKUP: begin
				if (it.weight_select != SEL_NONE) begin
					arc = first_arc(it.from_node, it.to_node);
					if (arc >= 0) begin
						r.weight_out = wt_mem[it.weight_select][arc];
						r.status     = ST_DONE;
					end else begin
						r.weight_out = no_path_w;
						r.status     = ST_NONE;
					end
				end
			end
			OP_UPDATE: begin
				if (it.weight_select == SEL_UP || it.weight_select == SEL_DOWN) begin
					arc = first_arc(it.from_node, it.to_node);
					if (arc >= 0) begin
						wt_mem[it.weight_select][arc]   = it.data_value & WEIGHT_MASK;
						wt_known[it.weight_select][arc] = 1'b1;
						r.status = ST_DONE;
					end else begin
						r.weight_out = no_path_w;
						r.status     = ST_NONE;
					end
				end
			end
			default: ;
		endcase
		pending_rsp.push_back(r);
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.opcode        = 3'($urandom_range(0, 7));
		it.slot          = 12'($urandom_range(0, 4095));
		it.from_node     = 10'($urandom_range(0, NODE_COUNT - 1));
		it.to_node       = 10'($urandom_range(0, NODE_COUNT - 1));
		it.weight_select = 2'($urandom_range(0, 3));
		it.data_value    = $urandom;
		return it;
	endfunction

	function automatic item_t req(input logic [2:0] op, input logic [11:0] slot,
			input logic [9:0] src, input logic [9:0] dst, input logic [1:0] sel,
			input logic [31:0] val);
		item_t it;
		it.opcode        = op;
		it.slot          = slot;
		it.from_node     = src;
		it.to_node       = dst;
		it.weight_select = sel;
		it.data_value    = val;
		return it;
	endfunction

	// request beat: random gap, then hold until accepted
	task automatic send_item(input item_t it);
		int gap;
		gap = $urandom_range(0, idle_max);
		repeat (gap) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_data  <= it;
		do @(posedge clk); while (cmd_stall);
		table_apply(it);
	endtask

	// queries go out only when every entry they read has been loaded
	task automatic send_query(input item_t it, output bit sent);
		sent = reads_defined(it);
		if (sent)
			send_item(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [31:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		no_path_w = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// load one node: its two offsets, targets and all three weights per arc
	task automatic load_node(input int node, input int base, input int deg);
		item_t it;
		int    r;
		it = rand_item();
		it.opcode = OP_WR_OFFSET; it.slot = 12'(node); it.data_value = 32'(base);
		send_item(it);
		it = rand_item();
		it.opcode = OP_WR_OFFSET; it.slot = 12'(node + 1); it.data_value = 32'(base + deg);
		send_item(it);
		for (int i = 0; i < deg; i++) begin
			it = rand_item();
			it.opcode = OP_WR_TARGET;
			it.slot   = 12'(base + i);
			r = $urandom_range(0, 19);
			// small targets make repeated targets and first-match cases likely
			it.data_value = (r < 6) ? $urandom_range(0, 7) :
				(r == 19) ? $urandom : $urandom_range(0, NODE_COUNT - 1);
			send_item(it);
		end
		for (int i = 0; i < deg; i++)
			for (int s = SEL_PLAIN; s <= SEL_DOWN; s++) begin
				it = rand_item();
				it.opcode        = OP_WR_WEIGHT;
				it.slot          = 12'(base + i);
				it.weight_select = 2'(s);
				send_item(it);
			end
		built_nodes.push_back(node);
	endtask

	// write extremes, rejected slots and values, selector three
	task automatic test_loads();
		idle_max = 12;
		send_item(req(OP_WR_OFFSET, 12'd1025, 10'd0, 10'd0, SEL_PLAIN, 32'd3));
		send_item(req(OP_WR_OFFSET, 12'd4095, 10'd0, 10'd0, SEL_PLAIN, 32'd0));
		send_item(req(OP_WR_OFFSET, 12'd1023, 10'd0, 10'd0, SEL_PLAIN, 32'd4094));
		send_item(req(OP_WR_OFFSET, 12'd1024, 10'd0, 10'd0, SEL_PLAIN, 32'hFFFF_FFFF));
		send_item(req(OP_WR_TARGET, 12'd4095, 10'd0, 10'd0, SEL_PLAIN, 32'd1023));
		send_item(req(OP_WR_TARGET, 12'd4094, 10'd0, 10'd0, SEL_PLAIN, 32'd0));
		send_item(req(OP_WR_TARGET, 12'd4093, 10'd0, 10'd0, SEL_PLAIN, 32'd1024));
		send_item(req(OP_WR_TARGET, 12'd0, 10'd0, 10'd0, SEL_PLAIN, 32'hFFFF_FFFF));
		send_item(req(OP_WR_WEIGHT, 12'd4095, 10'd0, 10'd0, SEL_PLAIN, 32'hFFFF_FFFF));
		send_item(req(OP_WR_WEIGHT, 12'd4095, 10'd0, 10'd0, SEL_UP, 32'h0));
		send_item(req(OP_WR_WEIGHT, 12'd4095, 10'd0, 10'd0, SEL_DOWN, 32'h8000_0001));
		send_item(req(OP_WR_WEIGHT, 12'd4094, 10'd0, 10'd0, SEL_NONE, 32'h5555_AAAA));
		send_item(req(OP_WR_WEIGHT, 12'd4094, 10'd0, 10'd0, SEL_PLAIN, 32'd5));
	endtask

	// hits, misses, plain update and selector three on the last node
	task automatic test_queries();
		idle_max = 12;
		send_item(req(OP_LOOKUP, 12'd0, 10'd1023, 10'd1023, SEL_PLAIN, 32'h0));
		send_item(req(OP_LOOKUP, 12'd0, 10'd1023, 10'd0, SEL_PLAIN, 32'hFFFF_FFFF));
		send_item(req(OP_LOOKUP, 12'd0, 10'd1023, 10'd5, SEL_UP, 32'h0));
		send_item(req(OP_LOOKUP, 12'd0, 10'd1023, 10'd1023, SEL_NONE, 32'h0));
		send_item(req(OP_UPDATE, 12'd0, 10'd1023, 10'd1023, SEL_UP, 32'h1234_5678));
		send_item(req(OP_LOOKUP, 12'd0, 10'd1023, 10'd1023, SEL_UP, 32'h0));
		send_item(req(OP_UPDATE, 12'd0, 10'd1023, 10'd1023, SEL_PLAIN, 32'h0));
		send_item(req(OP_UPDATE, 12'd0, 10'd1023, 10'd9, SEL_DOWN, 32'h0));
		send_item(req(OP_UPDATE, 12'd0, 10'd1023, 10'd1023, SEL_NONE, 32'h0));
	endtask

	// empty and inverted arc ranges, undefined opcodes
	task automatic test_spans();
		item_t it;
		idle_max = 12;
		send_item(req(OP_WR_OFFSET, 12'd0, 10'd0, 10'd0, SEL_PLAIN, 32'd10));
		send_item(req(OP_WR_OFFSET, 12'd1, 10'd0, 10'd0, SEL_PLAIN, 32'd10));
		send_item(req(OP_WR_OFFSET, 12'd2, 10'd0, 10'd0, SEL_PLAIN, 32'd3));
		send_item(req(OP_LOOKUP, 12'd0, 10'd0, 10'd0, SEL_PLAIN, 32'h0));
		send_item(req(OP_LOOKUP, 12'd0, 10'd1, 10'd0, SEL_UP, 32'h0));
		it = rand_item(); it.opcode = OP_SPARE_A; send_item(it);
		it = rand_item(); it.opcode = OP_SPARE_B; send_item(it);
		it = rand_item(); it.opcode = OP_SPARE_C; send_item(it);
	endtask

	// response side held off long enough to fill the block, then a full pause
	task automatic test_backpressure();
		item_t it;
		bit    sent;
		idle_max        = 0;
		rsp_hold_cycles = 150;
		for (int i = 0; i < 36; i++) begin
			it = rand_item();
			it.opcode        = (i % 4 == 3) ? OP_UPDATE : OP_LOOKUP;
			it.from_node     = 10'(NODE_COUNT - 1);
			it.to_node       = $urandom_range(0, 1) ? 10'(NODE_COUNT - 1) :
				10'($urandom_range(0, 3));
			it.weight_select = (it.opcode == OP_UPDATE) ? SEL_DOWN : SEL_PLAIN;
			send_query(it, sent);
			if (i == 24)
				wait_drained();
		end
		idle_max = 12;
	endtask

	// well-formed load and query sequences mixed with random noise
	task automatic test_random(input int count, input int gap_max);
		item_t it;
		bit    sent;
		int    n_sent;
		int    node;
		int    deg;
		int    base;
		int    a;
		idle_max = gap_max;
		n_sent   = 0;
		while (n_sent < count) begin
			if ($urandom_range(0, 99) < 60) begin
				node = $urandom_range(0, NODE_COUNT - 1);
				deg  = $urandom_range(0, 5);
				base = $urandom_range(0, ARC_COUNT - deg);
				load_node(node, base, deg);
				n_sent += 2 + 4 * deg;
				repeat ($urandom_range(2, 6)) begin
					it = rand_item();
					it.opcode    = ($urandom_range(0, 2) == 0) ? OP_UPDATE : OP_LOOKUP;
					it.from_node = 10'(node);
					if (deg > 0 && $urandom_range(0, 3) != 0) begin
						a = base + $urandom_range(0, deg - 1);
						if (tgt_known[a])
							it.to_node = tgt_mem[a];
					end
					it.weight_select = ($urandom_range(0, 9) == 0) ? SEL_NONE :
						2'($urandom_range(0, 2));
					send_query(it, sent);
					n_sent += int'(sent);
				end
			end else begin
				it = rand_item();
				if (built_nodes.size() != 0 && $urandom_range(0, 1))
					it.from_node = 10'(built_nodes[$urandom_range(0, built_nodes.size() - 1)]);
				if (it.opcode == OP_WR_TARGET && $urandom_range(0, 1))
					it.data_value = $urandom_range(0, NODE_COUNT - 1);
				send_query(it, sent);
				// unloaded entries would be read: turn it into a weight write
				if (!sent) begin
					it.opcode = OP_WR_WEIGHT;
					send_item(it);
				end
				n_sent++;
			end
		end
	endtask

	// response side: random stall per beat plus an optional long hold
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				rsp_hold_cycles--;
			end else if (rsp_wait_left > 0) begin
				rsp_stall <= 1'b1;
				rsp_wait_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// compare each response beat with the oldest owed result
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected beat", rsp_data.weight_out, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_data.weight_out !== want.weight_out)
					report_mismatch("weight_out", rsp_data.weight_out, want.weight_out);
				if (rsp_data.status !== want.status)
					report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
			end
			rsp_wait_left = $urandom_range(0, idle_max);
		end
	end

	// test sequence
	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_data  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		no_path_w = '1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_loads();
		test_queries();
		cfg_write(32'h0);
		test_spans();
		cfg_write(32'hFFFF_FFFF);
		test_backpressure();
		cfg_write($urandom);
		test_random(400, 12);
		test_random(300, 0);
		cfg_write(32'h0);
		test_random(300, 12);
		wait_drained();

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
